FILE: sv/mfmc_pkg.sv
// ----------------------------------------------------------------------------
// mfmc_pkg
// Shared constants, state and operation codes, and the structures that pass
// between the controller and the datapath of the max-flow engine.
// ----------------------------------------------------------------------------
package mfmc_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MAX_DEGREE   = 16;

  localparam int VW   = $clog2(MAX_VERTICES);
  localparam int SW   = $clog2(MAX_DEGREE);
  localparam int EW   = VW + SW;
  localparam int CNTW = VW + 1;
  localparam int DEGW = SW + 1;
  localparam int CAPW = 32;
  localparam int FLOWW = 33;
  localparam int VALW = 40;
  localparam int CUTW = 11;
  localparam int STW  = 2;
  localparam int MODEW = 3;

  localparam logic [DEGW:0] DEG_LIMIT = (DEGW+1)'(MAX_DEGREE);

  localparam logic [MODEW-1:0] MODE_ADD   = 3'd0;
  localparam logic [MODEW-1:0] MODE_FLOW  = 3'd1;
  localparam logic [MODEW-1:0] MODE_CUT   = 3'd2;
  localparam logic [MODEW-1:0] MODE_QUERY = 3'd3;
  localparam logic [MODEW-1:0] MODE_CLEAR = 3'd4;

  localparam logic [STW-1:0] ST_OK    = 2'd0;
  localparam logic [STW-1:0] ST_RANGE = 2'd1;
  localparam logic [STW-1:0] ST_FULL  = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_ADD_RDB, S_ADD_CHK, S_ADD_W2, S_Q_DEG, S_Q_SLOT, S_Q_CHK,
    S_FCLR, S_WALK_INIT, S_W_POP, S_W_U, S_W_DEG, S_W_SLOT, S_W_EDGE, S_AUG_RD,
    S_AUG_CHK, S_AUG_V, S_AUG_E, S_AUG_F, S_AUG_P, S_CUT_INIT, S_CUT_V, S_CUT_DG,
    S_CUT_SLOT, S_CUT_EDGE, S_EMIT, S_EMIT_CUT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_ERR1, OP_ERR2, OP_CLRDEG, OP_ADD_RDB, OP_ADD_W1,
    OP_ADD_W2, OP_DEG_LATCH, OP_ADJ_Q, OP_Q_CHK, OP_FCLR_INIT, OP_FCLR,
    OP_WALK_INIT, OP_POP, OP_U, OP_ADJ_U, OP_W_EDGE, OP_BN_SNK, OP_AUG_INIT,
    OP_SET_CUT, OP_AUG_E, OP_AUG_F, OP_AUG_P, OP_CUT_INIT, OP_CUT_NEXT,
    OP_CUT_DEG, OP_ADJ_C, OP_CUT_EDGE, OP_EMIT, OP_EMIT_CUT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic [MODEW-1:0] mode;
    logic             in_range;
    logic             a_eq_b;
    logic             add_full;
    logic             sw_last;
    logic             head_eq_tail;
    logic             u_is_snk;
    logic             slot_done;
    logic             snk_reached;
    logic             aug_done;
    logic             q_match;
    logic             cv_done;
    logic             cv_vis;
    logic             ev_last;
    logic             out_free;
    logic             cut_phase;
  } stat_t;

  typedef struct packed {
    logic [STW-1:0]  status;
    logic [VALW-1:0] value;
    logic [CUTW-1:0] cut_edges;
    logic [VW-1:0]   vertex;
    logic            source_side;
    logic            last;
  } res_t;

endpackage

FILE: sv/mfmc_ctrl.sv
// ----------------------------------------------------------------------------
// mfmc_ctrl
// Sequencer of the max-flow engine: walks each word through edge loads,
// queries, clears, breadth-first searches, augmentations and cut counting.
// ----------------------------------------------------------------------------
module mfmc_ctrl import mfmc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  stat_t st,
  output logic  in_ready,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.op    = OP_ACCEPT;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (st.mode <= MODE_QUERY && !st.in_range) begin
          cmd.op    = OP_ERR1;
          state_nxt = S_EMIT;
        end else if ((st.mode == MODE_FLOW || st.mode == MODE_CUT) && st.a_eq_b) begin
          cmd.op    = OP_ERR1;
          state_nxt = S_EMIT;
        end else if (st.mode == MODE_ADD) begin
          state_nxt = S_ADD_RDB;
        end else if (st.mode == MODE_FLOW || st.mode == MODE_CUT) begin
          cmd.op    = OP_FCLR_INIT;
          state_nxt = S_FCLR;
        end else if (st.mode == MODE_QUERY) begin
          state_nxt = S_Q_DEG;
        end else if (st.mode == MODE_CLEAR) begin
          cmd.op    = OP_CLRDEG;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_ADD_RDB: begin
        cmd.op    = OP_ADD_RDB;
        state_nxt = S_ADD_CHK;
      end
      S_ADD_CHK: begin
        if (st.add_full) begin
          cmd.op    = OP_ERR2;
          state_nxt = S_EMIT;
        end else begin
          cmd.op    = OP_ADD_W1;
          state_nxt = S_ADD_W2;
        end
      end
      S_ADD_W2: begin
        cmd.op    = OP_ADD_W2;
        state_nxt = S_EMIT;
      end
      S_Q_DEG: begin
        cmd.op    = OP_DEG_LATCH;
        state_nxt = S_Q_SLOT;
      end
      S_Q_SLOT: begin
        if (st.slot_done) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.op    = OP_ADJ_Q;
          state_nxt = S_Q_CHK;
        end
      end
      S_Q_CHK: begin
        cmd.op    = OP_Q_CHK;
        state_nxt = st.q_match ? S_EMIT : S_Q_SLOT;
      end
      S_FCLR: begin
        cmd.op = OP_FCLR;
        if (st.sw_last) begin
          state_nxt = S_WALK_INIT;
        end
      end
      S_WALK_INIT: begin
        cmd.op    = OP_WALK_INIT;
        state_nxt = S_W_POP;
      end
      S_W_POP: begin
        if (st.head_eq_tail) begin
          state_nxt = st.cut_phase ? S_CUT_INIT : S_AUG_RD;
        end else begin
          cmd.op    = OP_POP;
          state_nxt = S_W_U;
        end
      end
      S_W_U: begin
        if (!st.cut_phase && st.u_is_snk) begin
          state_nxt = S_AUG_RD;
        end else begin
          cmd.op    = OP_U;
          state_nxt = S_W_DEG;
        end
      end
      S_W_DEG: begin
        cmd.op    = OP_DEG_LATCH;
        state_nxt = S_W_SLOT;
      end
      S_W_SLOT: begin
        if (st.slot_done) begin
          state_nxt = S_W_POP;
        end else begin
          cmd.op    = OP_ADJ_U;
          state_nxt = S_W_EDGE;
        end
      end
      S_W_EDGE: begin
        cmd.op    = OP_W_EDGE;
        state_nxt = S_W_SLOT;
      end
      S_AUG_RD: begin
        cmd.op    = OP_BN_SNK;
        state_nxt = S_AUG_CHK;
      end
      S_AUG_CHK: begin
        if (st.snk_reached) begin
          cmd.op    = OP_AUG_INIT;
          state_nxt = S_AUG_V;
        end else if (st.mode == MODE_FLOW) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.op    = OP_SET_CUT;
          state_nxt = S_WALK_INIT;
        end
      end
      S_AUG_V: begin
        state_nxt = st.aug_done ? S_WALK_INIT : S_AUG_E;
      end
      S_AUG_E: begin
        cmd.op    = OP_AUG_E;
        state_nxt = S_AUG_F;
      end
      S_AUG_F: begin
        cmd.op    = OP_AUG_F;
        state_nxt = S_AUG_P;
      end
      S_AUG_P: begin
        cmd.op    = OP_AUG_P;
        state_nxt = S_AUG_V;
      end
      S_CUT_INIT: begin
        cmd.op    = OP_CUT_INIT;
        state_nxt = S_CUT_V;
      end
      S_CUT_V: begin
        if (st.cv_done) begin
          state_nxt = S_EMIT_CUT;
        end else if (!st.cv_vis) begin
          cmd.op = OP_CUT_NEXT;
        end else begin
          cmd.op    = OP_CUT_DEG;
          state_nxt = S_CUT_DG;
        end
      end
      S_CUT_DG: begin
        cmd.op    = OP_DEG_LATCH;
        state_nxt = S_CUT_SLOT;
      end
      S_CUT_SLOT: begin
        if (st.slot_done) begin
          cmd.op    = OP_CUT_NEXT;
          state_nxt = S_CUT_V;
        end else begin
          cmd.op    = OP_ADJ_C;
          state_nxt = S_CUT_EDGE;
        end
      end
      S_CUT_EDGE: begin
        cmd.op    = OP_CUT_EDGE;
        state_nxt = S_CUT_SLOT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.op    = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      S_EMIT_CUT: begin
        if (st.out_free) begin
          cmd.op = OP_EMIT_CUT;
          if (st.ev_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/mfmc_dpath.sv
// ----------------------------------------------------------------------------
// mfmc_dpath
// Datapath of the max-flow engine: adjacency memories, search queue, parent
// and bottleneck memories, counters and the result register.
// ----------------------------------------------------------------------------
module mfmc_dpath import mfmc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  input  logic [MODEW-1:0] in_mode,
  input  logic [VW-1:0]    in_a,
  input  logic [VW-1:0]    in_b,
  input  logic [CAPW-1:0]  in_cap,
  input  logic [CNTW-1:0]  vcount,
  input  logic             deg_clr,
  input  logic             out_ready,
  output stat_t            st,
  output logic             out_valid,
  output res_t             res
);

  logic [VW-1:0]    adj_tgt_mem [2**EW];
  logic [CAPW-1:0]  adj_cap_mem [2**EW];
  logic [FLOWW-1:0] adj_flow_mem [2**EW];
  logic [SW-1:0]    adj_prt_mem [2**EW];
  logic [DEGW-1:0]  deg_mem [MAX_VERTICES];
  logic [EW-1:0]    par_mem [MAX_VERTICES];
  logic [CAPW-1:0]  bn_mem [MAX_VERTICES];
  logic [VW-1:0]    q_mem [MAX_VERTICES];

  logic [VW-1:0]    tgt_q;
  logic [CAPW-1:0]  cap_q;
  logic [FLOWW-1:0] flow_q;
  logic [SW-1:0]    prt_q;
  logic [DEGW-1:0]  deg_qd_r;
  logic             deg_qv_r;
  logic [EW-1:0]    par_q;
  logic [CAPW-1:0]  bn_q;
  logic [VW-1:0]    q_q;

  logic [MODEW-1:0] mode_r;
  logic [VW-1:0]    a_r, b_r, u_r, v_r;
  logic [CAPW-1:0]  cap_r, bnu_r, bval_r;
  logic [STW-1:0]   rstat_r;
  logic [VALW-1:0]  value_r;
  logic [CUTW-1:0]  cut_r;
  logic [DEGW-1:0]  da_r, bs_r, dg_r, slot_r;
  logic [CNTW-1:0]  guard_r, head_r, tail_r, cv_r, ev_r;
  logic [EW-1:0]    sw_r, ra_r;
  logic             cutph_r;
  logic [MAX_VERTICES-1:0] visited_r, deg_vld_r;
  logic             out_valid_r;
  res_t             res_r;

  logic [DEGW-1:0]  deg_q, bs_w1, deg_wdata;
  logic [EW-1:0]    adj_raddr, adj_waddr, flow_waddr;
  logic [VW-1:0]    deg_raddr, bn_raddr, deg_waddr, adj_wtgt;
  logic [CAPW-1:0]  adj_wcap;
  logic [SW-1:0]    adj_wprt;
  logic [FLOWW-1:0] flow_wdata;
  logic             adj_we, flow_we, deg_we, walk_we, init_we;
  logic [DEGW:0]    da_need;
  logic signed [FLOWW:0] resid;
  logic             res_pos, t_ok, walk_take, cut_take;
  logic [CAPW-1:0]  res_sat, bn_new;
  logic [VALW:0]    tot_sum;

  assign deg_q   = deg_qv_r ? deg_qd_r : '0;
  assign bs_w1   = (a_r == b_r) ? da_r + DEGW'(1) : deg_q;
  assign da_need = {1'b0, da_r} + ((a_r == b_r) ? (DEGW+1)'(2) : (DEGW+1)'(1));
  assign resid   = $signed({2'b00, cap_q}) - $signed({flow_q[FLOWW-1], flow_q});
  assign res_pos = !resid[FLOWW] && (resid != '0);
  assign res_sat = resid[CAPW] ? '1 : resid[CAPW-1:0];
  assign bn_new  = (res_sat < bnu_r) ? res_sat : bnu_r;
  assign t_ok    = ({1'b0, tgt_q} < vcount) && !visited_r[tgt_q];
  assign walk_take = t_ok && res_pos && !tail_r[CNTW-1];
  assign cut_take  = t_ok && (cap_q != '0);
  assign tot_sum   = {1'b0, value_r} + (VALW+1)'(bn_q);
  assign walk_we   = (cmd.op == OP_W_EDGE) && walk_take;
  assign init_we   = (cmd.op == OP_WALK_INIT);

  always_comb begin
    adj_raddr = ra_r;
    deg_raddr = a_r;
    bn_raddr  = b_r;
    case (cmd.op)
      OP_ADJ_U:   adj_raddr = {u_r, slot_r[SW-1:0]};
      OP_ADJ_Q:   adj_raddr = {a_r, slot_r[SW-1:0]};
      OP_ADJ_C:   adj_raddr = {cv_r[VW-1:0], slot_r[SW-1:0]};
      OP_AUG_E:   adj_raddr = par_q;
      OP_AUG_F:   adj_raddr = {tgt_q, prt_q};
      OP_ADD_RDB: deg_raddr = b_r;
      OP_CUT_DEG: deg_raddr = cv_r[VW-1:0];
      OP_U: begin
        deg_raddr = q_q;
        bn_raddr  = q_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    adj_we     = 1'b0;
    adj_waddr  = {a_r, da_r[SW-1:0]};
    adj_wtgt   = b_r;
    adj_wcap   = cap_r;
    adj_wprt   = bs_w1[SW-1:0];
    flow_we    = 1'b0;
    flow_waddr = ra_r;
    flow_wdata = '0;
    deg_we     = 1'b0;
    deg_waddr  = a_r;
    deg_wdata  = da_r + DEGW'(1);
    case (cmd.op)
      OP_ADD_W1: begin
        adj_we     = 1'b1;
        flow_we    = 1'b1;
        flow_waddr = adj_waddr;
        deg_we     = 1'b1;
      end
      OP_ADD_W2: begin
        adj_we     = 1'b1;
        adj_waddr  = {b_r, bs_r[SW-1:0]};
        adj_wtgt   = a_r;
        adj_wcap   = '0;
        adj_wprt   = da_r[SW-1:0];
        flow_we    = 1'b1;
        flow_waddr = {b_r, bs_r[SW-1:0]};
        deg_we     = 1'b1;
        deg_waddr  = b_r;
        deg_wdata  = bs_r + DEGW'(1);
      end
      OP_FCLR: begin
        flow_we    = 1'b1;
        flow_waddr = sw_r;
      end
      OP_AUG_F: begin
        flow_we    = 1'b1;
        flow_wdata = flow_q + {1'b0, bval_r};
      end
      OP_AUG_P: begin
        flow_we    = 1'b1;
        flow_wdata = flow_q - {1'b0, bval_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_tgt_mem[adj_waddr] <= adj_wtgt;
      adj_cap_mem[adj_waddr] <= adj_wcap;
      adj_prt_mem[adj_waddr] <= adj_wprt;
    end
    if (flow_we) begin
      adj_flow_mem[flow_waddr] <= flow_wdata;
    end
    tgt_q  <= adj_tgt_mem[adj_raddr];
    cap_q  <= adj_cap_mem[adj_raddr];
    flow_q <= adj_flow_mem[adj_raddr];
    prt_q  <= adj_prt_mem[adj_raddr];
  end

  always_ff @(posedge clk) begin
    if (deg_we) begin
      deg_mem[deg_waddr] <= deg_wdata;
    end
    deg_qd_r <= deg_mem[deg_raddr];
    deg_qv_r <= deg_vld_r[deg_raddr];
  end

  always_ff @(posedge clk) begin
    if (walk_we) begin
      par_mem[tgt_q] <= ra_r;
    end
    par_q <= par_mem[v_r];
  end

  always_ff @(posedge clk) begin
    if (walk_we) begin
      bn_mem[tgt_q] <= bn_new;
    end else if (init_we) begin
      bn_mem[a_r] <= '1;
    end
    bn_q <= bn_mem[bn_raddr];
  end

  always_ff @(posedge clk) begin
    if (walk_we) begin
      q_mem[tail_r[VW-1:0]] <= tgt_q;
    end else if (init_we) begin
      q_mem[0] <= a_r;
    end
    q_q <= q_mem[head_r[VW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      visited_r   <= '0;
      deg_vld_r   <= '0;
      cutph_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (deg_clr || cmd.op == OP_CLRDEG) begin
        deg_vld_r <= '0;
      end else if (deg_we) begin
        deg_vld_r[deg_waddr] <= 1'b1;
      end
      if (init_we) begin
        visited_r <= MAX_VERTICES'(1) << a_r;
      end else if (walk_we) begin
        visited_r[tgt_q] <= 1'b1;
      end
      if (cmd.op == OP_FCLR_INIT) begin
        cutph_r <= 1'b0;
      end else if (cmd.op == OP_SET_CUT) begin
        cutph_r <= 1'b1;
      end
      if (cmd.op == OP_EMIT || cmd.op == OP_EMIT_CUT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ra_r <= adj_raddr;
    case (cmd.op)
      OP_ACCEPT: begin
        mode_r  <= in_mode;
        a_r     <= in_a;
        b_r     <= in_b;
        cap_r   <= in_cap;
        rstat_r <= ST_OK;
        value_r <= '0;
        cut_r   <= '0;
      end
      OP_ERR1: rstat_r <= ST_RANGE;
      OP_ERR2: rstat_r <= ST_FULL;
      OP_ADD_RDB: da_r <= deg_q;
      OP_ADD_W1: bs_r <= bs_w1;
      OP_DEG_LATCH: begin
        dg_r   <= deg_q;
        bnu_r  <= bn_q;
        slot_r <= '0;
      end
      OP_Q_CHK: begin
        if (tgt_q == b_r && cap_q != '0) begin
          value_r <= flow_q[FLOWW-1] ? '0 : VALW'(flow_q[CAPW-1:0]);
        end
        slot_r <= slot_r + DEGW'(1);
      end
      OP_FCLR_INIT: sw_r <= '0;
      OP_FCLR: sw_r <= sw_r + EW'(1);
      OP_WALK_INIT: begin
        head_r <= '0;
        tail_r <= CNTW'(1);
      end
      OP_POP: head_r <= head_r + CNTW'(1);
      OP_U: u_r <= q_q;
      OP_W_EDGE: begin
        if (walk_take) begin
          tail_r <= tail_r + CNTW'(1);
        end
        slot_r <= slot_r + DEGW'(1);
      end
      OP_AUG_INIT: begin
        bval_r  <= bn_q;
        v_r     <= b_r;
        guard_r <= '0;
        value_r <= tot_sum[VALW] ? '1 : tot_sum[VALW-1:0];
      end
      OP_AUG_F: begin
        v_r     <= ra_r[EW-1:SW];
        guard_r <= guard_r + CNTW'(1);
      end
      OP_CUT_INIT: begin
        cv_r <= '0;
        ev_r <= '0;
      end
      OP_CUT_NEXT: cv_r <= cv_r + CNTW'(1);
      OP_CUT_EDGE: begin
        if (cut_take) begin
          cut_r <= cut_r + CUTW'(1);
        end
        slot_r <= slot_r + DEGW'(1);
      end
      OP_EMIT: begin
        res_r.status      <= rstat_r;
        res_r.value       <= value_r;
        res_r.cut_edges   <= '0;
        res_r.vertex      <= '0;
        res_r.source_side <= 1'b0;
        res_r.last        <= 1'b1;
      end
      OP_EMIT_CUT: begin
        res_r.status      <= ST_OK;
        res_r.value       <= value_r;
        res_r.cut_edges   <= cut_r;
        res_r.vertex      <= ev_r[VW-1:0];
        res_r.source_side <= visited_r[ev_r[VW-1:0]];
        res_r.last        <= st.ev_last;
        ev_r              <= ev_r + CNTW'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    st.mode         = mode_r;
    st.in_range     = ({1'b0, a_r} < vcount) && ({1'b0, b_r} < vcount);
    st.a_eq_b       = (a_r == b_r);
    st.add_full     = (da_need > DEG_LIMIT) || (({1'b0, deg_q} + (DEGW+1)'(1)) > DEG_LIMIT);
    st.sw_last      = ({1'b0, sw_r} + (EW+1)'(1)) == {vcount, {SW{1'b0}}};
    st.head_eq_tail = (head_r == tail_r);
    st.u_is_snk     = (q_q == b_r);
    st.slot_done    = (slot_r >= dg_r);
    st.snk_reached  = visited_r[b_r] && (bn_q != '0);
    st.aug_done     = (v_r == a_r) || guard_r[CNTW-1];
    st.q_match      = (tgt_q == b_r) && (cap_q != '0);
    st.cv_done      = (cv_r == vcount);
    st.cv_vis       = visited_r[cv_r[VW-1:0]];
    st.ev_last      = (ev_r == vcount - CNTW'(1));
    st.out_free     = !out_valid_r || out_ready;
    st.cut_phase    = cutph_r;
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule

FILE: sv/max_flow_min_cut_engine.sv
// ----------------------------------------------------------------------------
// max_flow_min_cut_engine
// Edmonds-Karp maximum flow and minimum cut over a graph held in on-chip
// adjacency memories, with an APB register for the number of vertices.
// ----------------------------------------------------------------------------
// One word is processed at a time. An edge load, a load refused for a full list,
// a flow query, a clear and an out-of-range word each give one result. A flow run
// clears 16 flow entries per vertex in use, one a cycle, then runs searches over
// the queued vertices and their slots, walking each path found back edge by edge.
// A cut run then adds one more search, the cut count and one result a cycle while
// the output is not stalled. After reset the vertex count is 2 and no edges exist.
module max_flow_min_cut_engine import mfmc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // vertex_a, vertex_b, capacity, zero fill
  input  logic [2:0]  in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // status, value, cut_edges, vertex, source_side, zero fill
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [CNTW-1:0] vcount_r, cfg_n;
  logic            cfg_wr, deg_clr;
  cmd_t            cmd;
  stat_t           st;
  res_t            res;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2];
  assign cfg_n      = (cfg_pwdata[6:0] < 7'd2) ? 7'd2 :
                      (cfg_pwdata[6:0] > 7'(MAX_VERTICES)) ? 7'(MAX_VERTICES) :
                      cfg_pwdata[6:0];
  assign deg_clr    = cfg_wr && (cfg_n < vcount_r);
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {25'd0, vcount_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= 7'd2;
    end else if (cfg_wr) begin
      vcount_r <= cfg_n;
    end
  end

  mfmc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .st       (st),
    .in_ready (in_tready),
    .cmd      (cmd)
  );

  mfmc_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_mode   (in_tuser),
    .in_a      (in_tdata[5:0]),
    .in_b      (in_tdata[11:6]),
    .in_cap    (in_tdata[43:12]),
    .vcount    (vcount_r),
    .deg_clr   (deg_clr),
    .out_ready (out_tready),
    .st        (st),
    .out_valid (out_tvalid),
    .res       (res)
  );

  assign out_tdata = {4'd0, res.source_side, res.vertex, res.cut_edges, res.value, res.status};
  assign out_tlast = res.last;

  a_vcount_range: assert property (@(posedge clk) disable iff (!rst_n)
    vcount_r >= 7'd2 && vcount_r <= 7'(MAX_VERTICES))
    else $error("vertex count left its legal range");

  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word accepted while one is in progress");

  a_vertex_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> {1'b0, out_tdata[58:53]} < vcount_r)
    else $error("result names a vertex outside the graph");

endmodule
